// ===== rtl/core/rth_pkg.sv =====
// ============================================================================
// rth_pkg
// Shared widths, sector codes and pipeline word types for the RGB to HSV
// converter.
// ============================================================================
package rth_pkg;

    localparam int COMP_W          = 8;
    localparam int FRAC_BITS       = 16;
    localparam int SPAN_W          = 11;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = FRAC_BITS / STEPS_PER_STAGE;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // Word leaving the extrema stage
    typedef struct packed {
        logic [COMP_W-1:0] mx;
        logic [COMP_W-1:0] mn;
        sector_t           sel;
        logic [COMP_W-1:0] p;
        logic [COMP_W-1:0] q;
    } ext_word_t;

    // Word carried through the divider stages
    typedef struct packed {
        logic                 zero;
        logic [FRAC_BITS:0]   bri;
        logic [COMP_W-1:0]    mx;
        logic [COMP_W-1:0]    sat_rem;
        logic [FRAC_BITS:0]   sat_q;
        logic [SPAN_W-1:0]    span;
        logic [SPAN_W-1:0]    hue_rem;
        logic [FRAC_BITS-1:0] hue_q;
    } div_word_t;

endpackage

// ===== rtl/core/rth_extrema.sv =====
// ============================================================================
// rth_extrema
// First stage: find the largest and smallest component and the hue sector.
// ============================================================================
module rth_extrema (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rth_pkg::COMP_W-1:0] red,
    input  logic [rth_pkg::COMP_W-1:0] green,
    input  logic [rth_pkg::COMP_W-1:0] blue,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rth_pkg::ext_word_t        out_word
);

    logic               valid_reg;
    rth_pkg::ext_word_t word_reg;
    rth_pkg::ext_word_t word_next;

    always_comb
    begin
        word_next.mx = (red > green) ? red : green;
        if (blue > word_next.mx)
        begin
            word_next.mx = blue;
        end
        word_next.mn = (red < green) ? red : green;
        if (blue < word_next.mn)
        begin
            word_next.mn = blue;
        end
        // red wins ties, then green
        priority if (red == word_next.mx)
        begin
            word_next.sel = rth_pkg::SEC_RED;
            word_next.p   = green;
            word_next.q   = blue;
        end
        else if (green == word_next.mx)
        begin
            word_next.sel = rth_pkg::SEC_GREEN;
            word_next.p   = blue;
            word_next.q   = red;
        end
        else
        begin
            word_next.sel = rth_pkg::SEC_BLUE;
            word_next.p   = red;
            word_next.q   = green;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== rtl/core/rth_sector.sv =====
// ============================================================================
// rth_sector
// Second stage: spread, hue numerator, brightness and the first quotient bit.
// ============================================================================
module rth_sector (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rth_pkg::ext_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output rth_pkg::div_word_t out_word
);

    localparam int CW = rth_pkg::COMP_W;
    localparam int SW = rth_pkg::SPAN_W;
    localparam int FB = rth_pkg::FRAC_BITS;

    logic               valid_reg;
    rth_pkg::div_word_t word_reg;
    rth_pkg::div_word_t word_next;

    logic [CW-1:0] d;
    logic [SW-1:0] span;
    logic [SW-1:0] base;
    logic [CW:0]   diff;
    logic [SW:0]   tsum;
    logic [SW:0]   twrap;

    always_comb
    begin
        d    = in_word.mx - in_word.mn;
        span = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
        diff = {1'b0, in_word.p} - {1'b0, in_word.q};
        unique case (in_word.sel)
            rth_pkg::SEC_RED:   base = '0;
            rth_pkg::SEC_GREEN: base = {2'b00, d, 1'b0};
            rth_pkg::SEC_BLUE:  base = {1'b0, d, 2'b00};
            default:            base = '0;
        endcase
        tsum  = {1'b0, base} + {{(SW - CW){diff[CW]}}, diff};
        // wrap a negative offset back onto the circle
        twrap = tsum + {1'b0, span};

        word_next.zero    = (d == '0);
        word_next.bri     = {1'b0, in_word.mx, {(FB - CW){1'b0}}}
                          + {{(FB + 1 - CW){1'b0}}, in_word.mx}
                          + {{FB{1'b0}}, (in_word.mx == {CW{1'b1}})};
        word_next.mx      = in_word.mx;
        word_next.span    = span;
        word_next.hue_rem = tsum[SW] ? twrap[SW-1:0] : tsum[SW-1:0];
        word_next.hue_q   = '0;
        if (d == in_word.mx)
        begin
            word_next.sat_q   = {{FB{1'b0}}, 1'b1};
            word_next.sat_rem = '0;
        end
        else
        begin
            word_next.sat_q   = '0;
            word_next.sat_rem = d;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== rtl/core/rth_div_stage.sv =====
// ============================================================================
// rth_div_stage
// One divider stage: STEPS_PER_STAGE restoring steps of both quotients.
// ============================================================================
module rth_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rth_pkg::div_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output rth_pkg::div_word_t out_word
);

    localparam int CW = rth_pkg::COMP_W;
    localparam int SW = rth_pkg::SPAN_W;
    localparam int FB = rth_pkg::FRAC_BITS;

    logic               valid_reg;
    rth_pkg::div_word_t word_reg;
    rth_pkg::div_word_t word_next;

    function automatic rth_pkg::div_word_t div_steps(input rth_pkg::div_word_t w);
        rth_pkg::div_word_t o;
        logic [CW:0]        s2;
        logic [SW:0]        h2;
        o = w;
        for (int i = 0; i < rth_pkg::STEPS_PER_STAGE; i++)
        begin
            s2 = {o.sat_rem, 1'b0};
            if (s2 >= {1'b0, o.mx})
            begin
                s2      = s2 - {1'b0, o.mx};
                o.sat_q = {o.sat_q[FB-1:0], 1'b1};
            end
            else
            begin
                o.sat_q = {o.sat_q[FB-1:0], 1'b0};
            end
            o.sat_rem = s2[CW-1:0];

            h2 = {o.hue_rem, 1'b0};
            if (h2 >= {1'b0, o.span})
            begin
                h2      = h2 - {1'b0, o.span};
                o.hue_q = {o.hue_q[FB-2:0], 1'b1};
            end
            else
            begin
                o.hue_q = {o.hue_q[FB-2:0], 1'b0};
            end
            o.hue_rem = h2[SW-1:0];
        end
        return o;
    endfunction

    assign word_next = div_steps(in_word);
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== rtl/core/rgb_to_hsv_pixel.sv =====
// ============================================================================
// rgb_to_hsv_pixel
// Pipelined conversion of 8-bit RGB pixels to hue, saturation, brightness.
// ============================================================================
// Accepts one pixel word per clock as long as the output side does not stall,
// and returns one result word per pixel, in the order the pixels came in.
// The first stage finds the largest and smallest component and the hue
// sector; the second forms the spread, the hue numerator, the brightness
// (max/255 done as a multiply by 257 with a one-bit correction) and the top
// saturation bit. Eight divider stages then retire two quotient bits each of
// the two 16-bit restoring divisions, saturation = spread/max and
// hue = numerator/(6*spread), which set the depth. Every stage has its own
// valid bit and lets a word in when it is empty or its successor moves, so
// bubbles close up under backpressure and nothing is lost or repeated.
// Grey and black pixels report zero hue and saturation.
module rgb_to_hsv_pixel (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rth_pkg::COMP_W-1:0]   red,
    input  logic [rth_pkg::COMP_W-1:0]   green,
    input  logic [rth_pkg::COMP_W-1:0]   blue,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rth_pkg::FRAC_BITS-1:0] hue,
    output logic [rth_pkg::FRAC_BITS:0]   saturation,
    output logic [rth_pkg::FRAC_BITS:0]   brightness
);

    localparam int NS = rth_pkg::DIV_STAGES;

    // extrema -> sector handshake
    logic               ext_valid;
    logic               ext_ready;
    rth_pkg::ext_word_t ext_word;

    // divider chain: index 0 is the sector stage output
    logic               div_valid [0:NS];
    logic               div_ready [0:NS];
    rth_pkg::div_word_t div_word  [0:NS];

    rth_extrema u_extrema (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (ext_valid),
        .out_ready (ext_ready),
        .out_word  (ext_word)
    );

    rth_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ext_valid),
        .in_ready  (ext_ready),
        .in_word   (ext_word),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_word  (div_word[0])
    );

    // Advance both quotients STEPS_PER_STAGE bits per stage
    for (genvar s = 0; s < NS; s++)
    begin : g_div
        rth_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[s]),
            .in_ready  (div_ready[s]),
            .in_word   (div_word[s]),
            .out_valid (div_valid[s+1]),
            .out_ready (div_ready[s+1]),
            .out_word  (div_word[s+1])
        );
    end

    assign div_ready[NS] = out_ready;
    assign out_valid     = div_valid[NS];

    // Drop the quotients of grey and black pixels: their hue divisor was zero
    assign hue        = div_word[NS].zero ? '0 : div_word[NS].hue_q;
    assign saturation = div_word[NS].zero ? '0 : div_word[NS].sat_q;
    assign brightness = div_word[NS].bri;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (saturation <= {1'b1, {rth_pkg::FRAC_BITS{1'b0}}}))
        else $error("saturation above 1.0");

    a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (brightness == '0)) |-> ((saturation == '0) && (hue == '0)))
        else $error("black pixel with nonzero hue or saturation");

    a_hue_needs_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (hue != '0)) |-> (saturation != '0))
        else $error("hue reported for a grey pixel");

    a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

endmodule

// ===== bench/rgb_to_hsv_pixel_tb.sv =====
// ============================================================================
// rgb_to_hsv_pixel_tb
// Self-checking bench for the RGB to HSV pixel converter.
// ============================================================================
// Walks a short table of hand-picked pixels first: black, white, the primaries,
// greys, ties between components and hue wrap-around. A few rows carry a
// typed-in result. Then it streams random pixels, mostly across the full
// range and partly shaped into greys, ties, rails, tiny values and tiny
// spreads. Untyped pixels are converted by an integer model in the bench.
// Each result word is compared field by field with the oldest pending
// conversion. Both sides stall at random but for one long full-rate run.
// ============================================================================
module rgb_to_hsv_pixel_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = rth_pkg::COMP_W;
    localparam int FB           = rth_pkg::FRAC_BITS;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_PCT     = 34;
    localparam int DRAIN_CAP    = 20000;
    localparam int TAIL_CYCLES  = 30;

    // One converted pixel, at the widths of the result ports
    typedef struct packed {
        logic [FB-1:0] hue;
        logic [FB:0]   sat;
        logic [FB:0]   bri;
    } hsv_word_t;

    // One row of the directed table; typed rows carry their own result
    typedef struct packed {
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
        logic          typed;
        hsv_word_t     res;
    } pixel_case_t;

    localparam int DIRECTED_N = 22;
    localparam pixel_case_t DIRECTED_CASES [DIRECTED_N] = '{
        // black pixel, white pixel and the three primaries
        '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0,     17'd0,     17'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0,     17'd0,     17'd65536}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0,     17'd65536, 17'd65536}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{16'd21845, 17'd65536, 17'd65536}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{16'd43690, 17'd65536, 17'd65536}},
        // greys and the smallest nonzero maxima
        '{8'd128, 8'd128, 8'd128, 1'b0, '0},
        '{8'd1,   8'd1,   8'd1,   1'b0, '0},
        '{8'd1,   8'd0,   8'd0,   1'b0, '0},
        '{8'd0,   8'd1,   8'd0,   1'b0, '0},
        '{8'd0,   8'd0,   8'd1,   1'b0, '0},
        // ties at the maximum: red beats green, green beats blue
        '{8'd255, 8'd255, 8'd0,   1'b0, '0},
        '{8'd0,   8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd0,   8'd255, 1'b0, '0},
        // negative hue numerator wrapping to just under a full turn, then mixed pixels
        '{8'd255, 8'd0,   8'd1,   1'b0, '0},
        '{8'd255, 8'd254, 8'd254, 1'b0, '0},
        '{8'd254, 8'd255, 8'd0,   1'b0, '0},
        '{8'd0,   8'd1,   8'd255, 1'b0, '0},
        '{8'd170, 8'd85,  8'd0,   1'b0, '0},
        '{8'd85,  8'd170, 8'd255, 1'b0, '0},
        '{8'd200, 8'd100, 8'd150, 1'b0, '0},
        '{8'd1,   8'd254, 8'd127, 1'b0, '0},
        '{8'd255, 8'd1,   8'd0,   1'b0, '0}
    };

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic          out_valid;
    logic          out_ready;
    logic [FB-1:0] hue;
    logic [FB:0]   saturation;
    logic [FB:0]   brightness;

    // Conversions waiting for their result word, oldest first
    hsv_word_t pending_hsv [$];
    int        mismatches = 0;
    // Set during the full-rate stretch: neither side idles
    logic      full_rate = 1'b0;

    rgb_to_hsv_pixel u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Exact integer conversion: every field truncated to 16 fraction bits.
    function automatic hsv_word_t convert_pixel(input logic [CW-1:0] r,
                                                input logic [CW-1:0] g,
                                                input logic [CW-1:0] b);
        int unsigned      rv, gv, bv;
        int unsigned      top, bottom, spread, span, offset, plus, minus, numer;
        rth_pkg::sector_t sector;
        hsv_word_t        res;
        rv = 32'(r);
        gv = 32'(g);
        bv = 32'(b);
        top    = (rv > gv) ? rv : gv;
        top    = (bv > top) ? bv : top;
        bottom = (rv < gv) ? rv : gv;
        bottom = (bv < bottom) ? bv : bottom;
        spread = top - bottom;
        res.bri = (FB + 1)'((top * 65536) / 255);
        res.sat = '0;
        res.hue = '0;
        // Black and grey pixels keep zero hue and saturation
        if (top != 0 && spread != 0)
        begin
            span    = 6 * spread;
            res.sat = (FB + 1)'((spread * 65536) / top);
            // Red is tested first, then green; blue takes what is left
            if (rv == top)
                sector = rth_pkg::SEC_RED;
            else if (gv == top)
                sector = rth_pkg::SEC_GREEN;
            else
                sector = rth_pkg::SEC_BLUE;
            unique case (sector)
                rth_pkg::SEC_RED:
                begin
                    offset = 0;
                    plus   = gv;
                    minus  = bv;
                end
                rth_pkg::SEC_GREEN:
                begin
                    offset = 2;
                    plus   = bv;
                    minus  = rv;
                end
                default:
                begin
                    offset = 4;
                    plus   = rv;
                    minus  = gv;
                end
            endcase
            // Add one full span first so the numerator never goes negative
            numer   = (offset * spread + span + plus - minus) % span;
            res.hue = FB'((numer * 65536) / span);
        end
        return res;
    endfunction

    // Present one pixel word, hold it until accepted, then queue its result.
    task automatic send_pixel(input logic [CW-1:0] r,
                              input logic [CW-1:0] g,
                              input logic [CW-1:0] b,
                              input hsv_word_t     res);
        // Random gap before the word; valid drops only inside the gap
        if (!full_rate)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_hsv.push_back(res);
    endtask

    // Result side: check every accepted word, then pick the next ready.
    initial
    begin
        hsv_word_t want;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_hsv.size() == 0)
                begin
                    $error("unexpected result word: hue %0d saturation %0d brightness %0d",
                           hue, saturation, brightness);
                    mismatches++;
                end
                else
                begin
                    want = pending_hsv.pop_front();
                    if (hue !== want.hue)
                    begin
                        $error("hue mismatch: expected %0d, actual %0d", want.hue, hue);
                        mismatches++;
                    end
                    if (saturation !== want.sat)
                    begin
                        $error("saturation mismatch: expected %0d, actual %0d",
                               want.sat, saturation);
                        mismatches++;
                    end
                    if (brightness !== want.bri)
                    begin
                        $error("brightness mismatch: expected %0d, actual %0d",
                               want.bri, brightness);
                        mismatches++;
                    end
                end
            end
            // Stall at random outside the full-rate stretch
            out_ready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [CW-1:0] r, g, b, base;
        int            shape;
        int            waited;
        hsv_word_t     left;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        red      <= '0;
        green    <= '0;
        blue     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: typed rows bring their own result
        for (int i = 0; i < DIRECTED_N; i++)
        begin
            if (DIRECTED_CASES[i].typed)
                send_pixel(DIRECTED_CASES[i].r, DIRECTED_CASES[i].g,
                           DIRECTED_CASES[i].b, DIRECTED_CASES[i].res);
            else
                send_pixel(DIRECTED_CASES[i].r, DIRECTED_CASES[i].g,
                           DIRECTED_CASES[i].b,
                           convert_pixel(DIRECTED_CASES[i].r, DIRECTED_CASES[i].g,
                                         DIRECTED_CASES[i].b));
        end

        // Random pixels; a long run in the middle goes at full rate
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            full_rate = (i >= 150 && i < 260);
            r     = CW'($urandom_range(255));
            g     = CW'($urandom_range(255));
            b     = CW'($urandom_range(255));
            shape = $urandom_range(9);
            case (shape)
                5:
                begin
                    // grey
                    g = r;
                    b = r;
                end
                6:
                begin
                    // two components tie at the maximum
                    base = (r > 8'd0) ? r : 8'd1;
                    b    = CW'($urandom_range(base - 1));
                    case ($urandom_range(2))
                        0:
                        begin
                            g = base;
                            r = base;
                        end
                        1:
                        begin
                            g = base;
                            b = base;
                            r = CW'($urandom_range(base - 1));
                        end
                        default:
                        begin
                            b = base;
                            r = base;
                            g = CW'($urandom_range(base - 1));
                        end
                    endcase
                end
                7:
                begin
                    // tiny values
                    r = CW'($urandom_range(3));
                    g = CW'($urandom_range(3));
                    b = CW'($urandom_range(3));
                end
                8:
                begin
                    // one channel at each rail
                    case ($urandom_range(2))
                        0:
                        begin
                            r = 8'd255;
                            g = 8'd0;
                        end
                        1:
                        begin
                            g = 8'd255;
                            b = 8'd0;
                        end
                        default:
                        begin
                            b = 8'd255;
                            r = 8'd0;
                        end
                    endcase
                end
                9:
                begin
                    // spread of at most one
                    base = (r > 8'd0) ? r : 8'd1;
                    g    = CW'(base - $urandom_range(1));
                    b    = CW'(base - $urandom_range(1));
                    r    = base;
                end
                default: ;
            endcase
            send_pixel(r, g, b, convert_pixel(r, g, b));
        end
        full_rate = 1'b0;
        in_valid <= 1'b0;

        // Drain, then idle long enough to catch a stray word
        waited = 0;
        while (pending_hsv.size() != 0 && waited < DRAIN_CAP)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        while (pending_hsv.size() != 0)
        begin
            left = pending_hsv.pop_front();
            $error("missing result word: hue %0d saturation %0d brightness %0d",
                   left.hue, left.sat, left.bri);
            mismatches++;
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial
    begin
        #1ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rth_pkg.sv
rtl/core/rth_extrema.sv
rtl/core/rth_sector.sv
rtl/core/rth_div_stage.sv
rtl/core/rgb_to_hsv_pixel.sv
bench/rgb_to_hsv_pixel_tb.sv
